FILE: hw/rtl/lav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lav_pkg;

  localparam int unsigned SQ_STEPS  = 31;
  localparam int unsigned DIV_STEPS = 17;
  // front 5 stages + sqrt steps + divider load + divide steps + sign stage
  localparam int unsigned NORM_LAT  = 5 + SQ_STEPS + 1 + DIV_STEPS + 1;

  typedef logic signed [31:0] fix_t;
  typedef logic signed [17:0] unit_t;
  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    fix_t  [2:0] eye;
    fix_t  [2:0] up;
    unit_t [2:0] fwd;
  } carry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lav_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lav_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic signed [31:0] up_x;
  logic signed [31:0] up_y;
  logic signed [31:0] up_z;

  modport source (
    output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
    input  ready
  );
  modport sink (
    input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/lav_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lav_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] side_x;
  logic signed [31:0] side_y;
  logic signed [31:0] side_z;
  logic signed [31:0] true_up_x;
  logic signed [31:0] true_up_y;
  logic signed [31:0] true_up_z;
  logic signed [31:0] back_x;
  logic signed [31:0] back_y;
  logic signed [31:0] back_z;
  logic signed [31:0] shift_side;
  logic signed [31:0] shift_up;
  logic signed [31:0] shift_forward;

  modport source (
    output valid, side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
           back_x, back_y, back_z, shift_side, shift_up, shift_forward,
    input  ready
  );
  modport sink (
    input  valid, side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
           back_x, back_y, back_z, shift_side, shift_up, shift_forward,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/lav_norm.sv
`timescale 1ns / 1ps
`default_nettype none

module lav_norm (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  lav_pkg::wide_t [2:0]     vec_i,
  output lav_pkg::unit_t [2:0]     unit_o
);

  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][29:0] mag;
  } side_t;

  // stage 1: sign and magnitude
  logic [2:0]       neg1_q;
  logic [2:0][62:0] mag1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= vec_i[i][63];
        mag1_q[i] <= vec_i[i][63] ? 63'(64'd0 - vec_i[i]) : vec_i[i][62:0];
      end
    end
  end

  // stage 2: leading one of the largest magnitude
  logic [62:0]      mag_or;
  logic [5:0]       msb;
  logic [2:0]       neg2_q;
  logic [2:0][62:0] mag2_q;
  logic [5:0]       msb2_q;
  logic             zero2_q;

  always_comb begin
    mag_or = mag1_q[0] | mag1_q[1] | mag1_q[2];
    msb    = '0;
    for (int b = 0; b < 63; b++) begin
      if (mag_or[b]) msb = 6'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg2_q  <= neg1_q;
      mag2_q  <= mag1_q;
      msb2_q  <= msb;
      zero2_q <= (mag_or == '0);
    end
  end

  // stage 3: scale so the largest lies in [2^29, 2^30)
  side_t side3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side3_q.zero <= zero2_q;
      side3_q.neg  <= neg2_q;
      for (int i = 0; i < 3; i++) begin
        if (msb2_q >= 6'd30) begin
          side3_q.mag[i] <= 30'(mag2_q[i] >> (msb2_q - 6'd29));
        end else begin
          side3_q.mag[i] <= 30'(mag2_q[i] << (6'd29 - msb2_q));
        end
      end
    end
  end

  // stage 4: squares
  logic [2:0][59:0] sq4_q;
  side_t            side4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side4_q <= side3_q;
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= 60'(side3_q.mag[i]) * 60'(side3_q.mag[i]);
      end
    end
  end

  // stage 5 and on: sum, then one root bit per stage
  logic [61:0] sq_rem_q  [0:lav_pkg::SQ_STEPS];
  logic [30:0] sq_root_q [0:lav_pkg::SQ_STEPS];
  side_t       sq_side_q [0:lav_pkg::SQ_STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_rem_q[0]  <= 62'(sq4_q[0]) + 62'(sq4_q[1]) + 62'(sq4_q[2]);
      sq_root_q[0] <= '0;
      sq_side_q[0] <= side4_q;
    end
  end

  for (genvar j = 0; j < lav_pkg::SQ_STEPS; j++) begin : g_sqrt
    localparam int K = lav_pkg::SQ_STEPS - 1 - j;
    logic [61:0] trial;
    logic        take;

    assign trial = (62'(sq_root_q[j]) << (K + 1)) + (62'd1 << (2 * K));
    assign take  = (sq_rem_q[j] >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_rem_q[j+1]  <= take ? (sq_rem_q[j] - trial) : sq_rem_q[j];
        sq_root_q[j+1] <= take ? (sq_root_q[j] | (31'd1 << K)) : sq_root_q[j];
        sq_side_q[j+1] <= sq_side_q[j];
      end
    end
  end

  // divider: q = floor((mag * 2^17 + len) / (2 * len)), one quotient bit per stage
  logic [2:0][47:0] dv_rem_q  [0:lav_pkg::DIV_STEPS];
  logic [2:0][16:0] dv_quo_q  [0:lav_pkg::DIV_STEPS];
  logic [31:0]      dv_div_q  [0:lav_pkg::DIV_STEPS];
  logic             dv_zero_q [0:lav_pkg::DIV_STEPS];
  logic [2:0]       dv_neg_q  [0:lav_pkg::DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= (48'(sq_side_q[lav_pkg::SQ_STEPS].mag[i]) << 17)
                          + 48'(sq_root_q[lav_pkg::SQ_STEPS]);
        dv_quo_q[0][i] <= '0;
      end
      dv_div_q[0]  <= {sq_root_q[lav_pkg::SQ_STEPS], 1'b0};
      dv_zero_q[0] <= sq_side_q[lav_pkg::SQ_STEPS].zero;
      dv_neg_q[0]  <= sq_side_q[lav_pkg::SQ_STEPS].neg;
    end
  end

  for (genvar j = 0; j < lav_pkg::DIV_STEPS; j++) begin : g_div
    localparam int I = lav_pkg::DIV_STEPS - 1 - j;
    logic [48:0] sub;

    assign sub = 49'(dv_div_q[j]) << I;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          if (49'(dv_rem_q[j][i]) >= sub) begin
            dv_rem_q[j+1][i] <= 48'(49'(dv_rem_q[j][i]) - sub);
            dv_quo_q[j+1][i] <= dv_quo_q[j][i] | (17'd1 << I);
          end else begin
            dv_rem_q[j+1][i] <= dv_rem_q[j][i];
            dv_quo_q[j+1][i] <= dv_quo_q[j][i];
          end
        end
        dv_div_q[j+1]  <= dv_div_q[j];
        dv_zero_q[j+1] <= dv_zero_q[j];
        dv_neg_q[j+1]  <= dv_neg_q[j];
      end
    end
  end

  // sign back on; a zero vector gives zero
  lav_pkg::unit_t [2:0] unit_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_q[lav_pkg::DIV_STEPS]) begin
          unit_q[i] <= '0;
        end else if (dv_neg_q[lav_pkg::DIV_STEPS][i]) begin
          unit_q[i] <= 18'd0 - {1'b0, dv_quo_q[lav_pkg::DIV_STEPS][i]};
        end else begin
          unit_q[i] <= {1'b0, dv_quo_q[lav_pkg::DIV_STEPS][i]};
        end
      end
    end
  end

  assign unit_o = unit_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lav_delay.sv
`timescale 1ns / 1ps
`default_nettype none

module lav_delay (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  lav_pkg::carry_t carry_i,
  output logic            valid_o,
  output lav_pkg::carry_t carry_o
);

  logic            valid_q [lav_pkg::NORM_LAT];
  lav_pkg::carry_t carry_q [lav_pkg::NORM_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lav_pkg::NORM_LAT; i++) valid_q[i] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int i = 1; i < lav_pkg::NORM_LAT; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      carry_q[0] <= carry_i;
      for (int i = 1; i < lav_pkg::NORM_LAT; i++) carry_q[i] <= carry_q[i-1];
    end
  end

  assign valid_o = valid_q[lav_pkg::NORM_LAT-1];
  assign carry_o = carry_q[lav_pkg::NORM_LAT-1];

endmodule

`default_nettype wire

FILE: hw/rtl/look_at_view_matrix_unit.sv
// Look-at view matrix unit (right handed, signed Q16.16).
// in_i: one transaction carries eye, target and up vectors. out_o: one
// transaction carries side, true up and back rows plus the three translations.
// Both channels use valid/ready; a transaction moves when both are high.
// Throughput: one transaction per cycle while out_o is not stalled. The path
// is two normalizers (55 stages each: sign, leading one, scale, squares, sum,
// 31 one-bit square-root stages, divider load, 17 one-bit divide stages, sign)
// plus input, cross product, true-up, dot-product and output stages.
// The whole pipeline advances while the output register is empty or taken;
// when the receiver stalls, every stage holds and in_i.ready drops in the
// same cycle, so nothing is lost or repeated.
// Reset clears all valid bits; the unit accepts input in the first cycle
// after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module look_at_view_matrix_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  lav_in_if.sink           in_i,
  lav_out_if.source        out_o
);

  localparam logic signed [55:0] SatMax = 56'sd2147483647;
  localparam logic signed [55:0] SatMin = -56'sd2147483648;

  function automatic lav_pkg::fix_t sat_round(input logic signed [55:0] x);
    logic signed [55:0] r;
    r = (x + 56'sd32768) >>> 16;
    if (r > SatMax) return 32'sh7fffffff;
    if (r < SatMin) return 32'sh80000000;
    return 32'(r);
  endfunction

  logic out_valid_q;
  logic adv;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // stage A: input register, target minus eye
  logic                 a_valid_q;
  lav_pkg::carry_t      a_carry_q;
  lav_pkg::wide_t [2:0] a_diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_valid_q <= 1'b0;
    else if (adv) a_valid_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_carry_q.eye <= {in_i.eye_z, in_i.eye_y, in_i.eye_x};
      a_carry_q.up  <= {in_i.up_z, in_i.up_y, in_i.up_x};
      a_carry_q.fwd <= '0;
      a_diff_q[0]   <= 64'(in_i.target_x) - 64'(in_i.eye_x);
      a_diff_q[1]   <= 64'(in_i.target_y) - 64'(in_i.eye_y);
      a_diff_q[2]   <= 64'(in_i.target_z) - 64'(in_i.eye_z);
    end
  end

  // forward normalization
  lav_pkg::unit_t [2:0] fwd;
  logic                 b_valid;
  lav_pkg::carry_t      b_carry;

  lav_norm u_norm_fwd (
    .clk_i  (clk_i),
    .en_i   (adv),
    .vec_i  (a_diff_q),
    .unit_o (fwd)
  );

  lav_delay u_delay_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (a_valid_q),
    .carry_i (a_carry_q),
    .valid_o (b_valid),
    .carry_o (b_carry)
  );

  // stage C: cross product terms forward x up
  logic               c_valid_q;
  lav_pkg::carry_t    c_carry_q;
  logic signed [49:0] c_prod_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_valid_q <= 1'b0;
    else if (adv) c_valid_q <= b_valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_carry_q.eye <= b_carry.eye;
      c_carry_q.up  <= b_carry.up;
      c_carry_q.fwd <= fwd;
      c_prod_q[0]   <= $signed(fwd[1]) * $signed(b_carry.up[2]);
      c_prod_q[1]   <= $signed(fwd[2]) * $signed(b_carry.up[1]);
      c_prod_q[2]   <= $signed(fwd[2]) * $signed(b_carry.up[0]);
      c_prod_q[3]   <= $signed(fwd[0]) * $signed(b_carry.up[2]);
      c_prod_q[4]   <= $signed(fwd[0]) * $signed(b_carry.up[1]);
      c_prod_q[5]   <= $signed(fwd[1]) * $signed(b_carry.up[0]);
    end
  end

  // stage D: cross differences
  logic                 d_valid_q;
  lav_pkg::carry_t      d_carry_q;
  lav_pkg::wide_t [2:0] d_cross_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_valid_q <= 1'b0;
    else if (adv) d_valid_q <= c_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_carry_q    <= c_carry_q;
      d_cross_q[0] <= 64'(c_prod_q[0]) - 64'(c_prod_q[1]);
      d_cross_q[1] <= 64'(c_prod_q[2]) - 64'(c_prod_q[3]);
      d_cross_q[2] <= 64'(c_prod_q[4]) - 64'(c_prod_q[5]);
    end
  end

  // side normalization
  lav_pkg::unit_t [2:0] side;
  logic                 e_valid;
  lav_pkg::carry_t      e_carry;

  lav_norm u_norm_side (
    .clk_i  (clk_i),
    .en_i   (adv),
    .vec_i  (d_cross_q),
    .unit_o (side)
  );

  lav_delay u_delay_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (d_valid_q),
    .carry_i (d_carry_q),
    .valid_o (e_valid),
    .carry_o (e_carry)
  );

  // T1: side x forward terms, side.eye and forward.eye terms
  logic                 t1_valid_q;
  lav_pkg::unit_t [2:0] t1_s_q;
  lav_pkg::unit_t [2:0] t1_f_q;
  lav_pkg::fix_t  [2:0] t1_eye_q;
  logic signed [35:0]   t1_sf_q [6];
  logic signed [49:0]   t1_se_q [3];
  logic signed [49:0]   t1_fe_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t1_valid_q <= 1'b0;
    else if (adv) t1_valid_q <= e_valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_s_q     <= side;
      t1_f_q     <= e_carry.fwd;
      t1_eye_q   <= e_carry.eye;
      t1_sf_q[0] <= $signed(side[1]) * $signed(e_carry.fwd[2]);
      t1_sf_q[1] <= $signed(side[2]) * $signed(e_carry.fwd[1]);
      t1_sf_q[2] <= $signed(side[2]) * $signed(e_carry.fwd[0]);
      t1_sf_q[3] <= $signed(side[0]) * $signed(e_carry.fwd[2]);
      t1_sf_q[4] <= $signed(side[0]) * $signed(e_carry.fwd[1]);
      t1_sf_q[5] <= $signed(side[1]) * $signed(e_carry.fwd[0]);
      for (int i = 0; i < 3; i++) begin
        t1_se_q[i] <= $signed(side[i]) * $signed(e_carry.eye[i]);
        t1_fe_q[i] <= $signed(e_carry.fwd[i]) * $signed(e_carry.eye[i]);
      end
    end
  end

  // T2: round true up, sum side.eye and forward.eye
  logic signed [36:0]   ud [3];
  logic                 t2_valid_q;
  lav_pkg::unit_t [2:0] t2_s_q;
  lav_pkg::unit_t [2:0] t2_f_q;
  lav_pkg::fix_t  [2:0] t2_eye_q;
  logic signed [19:0]   t2_u_q [3];
  logic signed [51:0]   t2_ds_q;
  logic signed [51:0]   t2_df_q;

  always_comb begin
    ud[0] = 37'(t1_sf_q[0]) - 37'(t1_sf_q[1]) + 37'sd32768;
    ud[1] = 37'(t1_sf_q[2]) - 37'(t1_sf_q[3]) + 37'sd32768;
    ud[2] = 37'(t1_sf_q[4]) - 37'(t1_sf_q[5]) + 37'sd32768;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t2_valid_q <= 1'b0;
    else if (adv) t2_valid_q <= t1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t2_s_q   <= t1_s_q;
      t2_f_q   <= t1_f_q;
      t2_eye_q <= t1_eye_q;
      for (int i = 0; i < 3; i++) t2_u_q[i] <= 20'(ud[i] >>> 16);
      t2_ds_q  <= 52'(t1_se_q[0]) + 52'(t1_se_q[1]) + 52'(t1_se_q[2]);
      t2_df_q  <= 52'(t1_fe_q[0]) + 52'(t1_fe_q[1]) + 52'(t1_fe_q[2]);
    end
  end

  // T3: true up . eye terms
  logic                 t3_valid_q;
  lav_pkg::unit_t [2:0] t3_s_q;
  lav_pkg::unit_t [2:0] t3_f_q;
  logic signed [19:0]   t3_u_q [3];
  logic signed [51:0]   t3_ue_q [3];
  logic signed [51:0]   t3_ds_q;
  logic signed [51:0]   t3_df_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t3_valid_q <= 1'b0;
    else if (adv) t3_valid_q <= t2_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t3_s_q  <= t2_s_q;
      t3_f_q  <= t2_f_q;
      t3_ds_q <= t2_ds_q;
      t3_df_q <= t2_df_q;
      for (int i = 0; i < 3; i++) begin
        t3_u_q[i]  <= t2_u_q[i];
        t3_ue_q[i] <= t2_u_q[i] * $signed(t2_eye_q[i]);
      end
    end
  end

  // T4: output register
  logic signed [55:0]  du;
  lav_pkg::fix_t [2:0] side_q;
  lav_pkg::fix_t [2:0] up_q;
  lav_pkg::fix_t [2:0] back_q;
  lav_pkg::fix_t       shift_side_q;
  lav_pkg::fix_t       shift_up_q;
  lav_pkg::fix_t       shift_fwd_q;

  assign du = 56'(t3_ue_q[0]) + 56'(t3_ue_q[1]) + 56'(t3_ue_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= t3_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        side_q[i] <= 32'($signed(t3_s_q[i]));
        up_q[i]   <= 32'(t3_u_q[i]);
        back_q[i] <= 32'sd0 - 32'($signed(t3_f_q[i]));
      end
      shift_side_q <= sat_round(56'sd0 - 56'(t3_ds_q));
      shift_up_q   <= sat_round(56'sd0 - du);
      shift_fwd_q  <= sat_round(56'(t3_df_q));
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.side_x        = side_q[0];
  assign out_o.side_y        = side_q[1];
  assign out_o.side_z        = side_q[2];
  assign out_o.true_up_x     = up_q[0];
  assign out_o.true_up_y     = up_q[1];
  assign out_o.true_up_z     = up_q[2];
  assign out_o.back_x        = back_q[0];
  assign out_o.back_y        = back_q[1];
  assign out_o.back_z        = back_q[2];
  assign out_o.shift_side    = shift_side_q;
  assign out_o.shift_up      = shift_up_q;
  assign out_o.shift_forward = shift_fwd_q;

endmodule

`default_nettype wire
